// File: src/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the byte-serial UTF-8 decoder with
// delimiter mapping.
// ----------------------------------------------------------------------------
package u8d_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] char_t;
	typedef logic [30:0] code_t;
	typedef logic [2:0]  due_t;
	typedef logic [2:0]  count_t;
	typedef logic [2:0]  cfg_index_t;
	typedef logic [15:0] cfg_data_t;

	// register indexes of the configuration port
	localparam cfg_index_t REG_DELIM_COUNT = 3'd0;
	localparam cfg_index_t REG_DELIM_A     = 3'd1;

	// delimiter table
	localparam int MAX_DELIMITERS = 4;
	localparam int DELIM_REGS     = 4;
	localparam int DELIM_LIMIT    = (MAX_DELIMITERS < DELIM_REGS) ? MAX_DELIMITERS : DELIM_REGS;

	localparam count_t COUNT_RESET = 3'd2;
	localparam char_t  DELIM_RESET [DELIM_REGS] = '{16'h0020, 16'h002C, 16'h0000, 16'h0000};

	// character codes
	localparam char_t CH_NUL   = 16'h0000;
	localparam char_t CH_LF    = 16'h000A;
	localparam char_t CH_CR    = 16'h000D;
	localparam char_t CH_SPACE = 16'h0020;

	// supplementary plane range, folded to space
	localparam code_t SUPP_LO = 31'h0001_0000;
	localparam code_t SUPP_HI = 31'h0010_FFFF;

	// decode result of one byte
	typedef struct packed {
		logic  valid;    // the byte yields a result beat
		logic  emit;     // result carries a decoded code point
		logic  at_end;
		logic  bad;
		code_t code;
	} dec_res_t;

endpackage

// File: src/u8d_if.sv
// ----------------------------------------------------------------------------
// u8d_if
// Valid/ready channels of the decoder: raw byte input and character output.
// ----------------------------------------------------------------------------
interface u8d_in_if;
	logic           valid;
	logic           ready;
	u8d_pkg::byte_t in_byte;
	logic           stream_end;
	logic           replace_delims;

	modport source (output valid, output in_byte, output stream_end,
		output replace_delims, input ready);
	modport sink (input valid, input in_byte, input stream_end,
		input replace_delims, output ready);
endinterface

interface u8d_out_if;
	logic           valid;
	logic           ready;
	u8d_pkg::char_t char_code;
	logic           at_end;
	logic           bad_sequence;

	modport source (output valid, output char_code, output at_end,
		output bad_sequence, input ready);
	modport sink (input valid, input char_code, input at_end,
		input bad_sequence, output ready);
endinterface

// File: src/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode
// Sequence state (partial code point, continuation bytes due) and the
// per-byte decode step.
// ----------------------------------------------------------------------------
module u8d_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  u8d_pkg::byte_t    in_byte,
	input  logic              stream_end,
	output u8d_pkg::dec_res_t res
);
	import u8d_pkg::*;

	code_t partial_q;
	due_t  due_q;
	code_t partial_d;
	due_t  due_d;
	code_t shifted;
	due_t  due_dec;
	logic  is_cont;

	assign is_cont = (in_byte[7:6] == 2'b10);
	assign shifted = {partial_q[24:0], in_byte[5:0]};
	assign due_dec = due_q - 3'd1;

	always_comb begin
		partial_d = partial_q;
		due_d     = due_q;
		res       = '0;
		if (stream_end) begin
			res.valid  = 1'b1;
			res.at_end = 1'b1;
			res.bad    = (due_q != '0);
			partial_d  = '0;
			due_d      = '0;
		end else if (due_q != '0) begin
			if (!is_cont) begin
				// broken sequence, offending byte is consumed
				res.valid = 1'b1;
				res.bad   = 1'b1;
				partial_d = '0;
				due_d     = '0;
			end else if (due_dec == '0) begin
				res.valid = 1'b1;
				res.emit  = 1'b1;
				res.code  = shifted;
				partial_d = '0;
				due_d     = '0;
			end else begin
				partial_d = shifted;
				due_d     = due_dec;
			end
		end else if (!in_byte[7]) begin
			res.valid = 1'b1;
			res.emit  = 1'b1;
			res.code  = {23'd0, in_byte};
		end else if (!is_cont) begin
			unique casez (in_byte)
				8'b110?_????: begin
					partial_d = {26'd0, in_byte[4:0]};
					due_d     = 3'd1;
				end
				8'b1110_????: begin
					partial_d = {27'd0, in_byte[3:0]};
					due_d     = 3'd2;
				end
				8'b1111_0???: begin
					partial_d = {28'd0, in_byte[2:0]};
					due_d     = 3'd3;
				end
				8'b1111_10??: begin
					partial_d = {29'd0, in_byte[1:0]};
					due_d     = 3'd4;
				end
				8'b1111_110?: begin
					partial_d = {30'd0, in_byte[0]};
					due_d     = 3'd5;
				end
				default: begin
					// 0xfe / 0xff skipped
					partial_d = partial_q;
					due_d     = due_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			due_q     <= '0;
		end else if (step) begin
			partial_q <= partial_d;
			due_q     <= due_d;
		end
	end

endmodule

// File: src/u8d_delim.sv
// ----------------------------------------------------------------------------
// u8d_delim
// Delimiter configuration registers and the code point to 16-bit
// character mapping.
// ----------------------------------------------------------------------------
module u8d_delim (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  u8d_pkg::cfg_index_t cfg_index,
	input  u8d_pkg::cfg_data_t  cfg_data,
	input  u8d_pkg::code_t      code,
	input  logic                replace,
	output u8d_pkg::char_t      char_code
);
	import u8d_pkg::*;

	count_t count_q;
	char_t  tbl_q [DELIM_REGS];
	count_t active;
	char_t  ch;
	logic   hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			for (int i = 0; i < DELIM_REGS; i++) begin
				tbl_q[i] <= DELIM_RESET[i];
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_DELIM_COUNT) begin
				count_q <= cfg_data[2:0];
			end
			for (int i = 0; i < DELIM_REGS; i++) begin
				if (cfg_index == cfg_index_t'(REG_DELIM_A + i)) begin
					tbl_q[i] <= cfg_data;
				end
			end
		end
	end

	assign active = (count_q > count_t'(DELIM_LIMIT)) ? count_t'(DELIM_LIMIT) : count_q;

	always_comb begin
		if (code >= SUPP_LO && code <= SUPP_HI) begin
			ch = CH_SPACE;
		end else begin
			ch = code[15:0];
		end
		hit = (ch == CH_NUL) || (ch == CH_CR) || (ch == CH_LF);
		for (int i = 0; i < DELIM_REGS; i++) begin
			if ((count_t'(i) < active) && (ch == tbl_q[i])) begin
				hit = 1'b1;
			end
		end
		char_code = (replace && hit) ? CH_NUL : ch;
	end

endmodule

// File: src/utf8_decoder_with_delimiters.sv
// ----------------------------------------------------------------------------
// utf8_decoder_with_delimiters
// Byte-serial UTF-8 decoder with 16-bit character output and optional
// delimiter mapping.
// ----------------------------------------------------------------------------
// Takes one byte beat per clock, unless a held result beat stalls the input,
// and returns at most one character beat per byte; this sustained rate is set
// by the single decode step between the input register and the result
// register. Lead bytes and inner continuation bytes only update the sequence
// state and return nothing; stray continuation bytes and 0xfe/0xff between
// sequences are dropped. The final byte of a sequence (or a plain ascii byte)
// returns the character: code points in the supplementary planes come out as
// space, larger ones are cut to 16 bits. With replace_delims set, NUL, CR, LF
// and the first delimiter_count entries of the delimiter table come out as 0.
// A broken sequence returns a beat with bad_sequence set; a stream_end beat
// returns at_end, flagged bad when it cuts a sequence short. The user must
// write delimiter registers through the plain write port (index 0 count, 1..4
// table) only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module utf8_decoder_with_delimiters (
	input  logic                clk,
	input  logic                arst_n,
	u8d_in_if.sink              in_ch,
	u8d_out_if.source           out_ch,
	input  logic                cfg_we,
	input  u8d_pkg::cfg_index_t cfg_index,
	input  u8d_pkg::cfg_data_t  cfg_data
);
	import u8d_pkg::*;

	// input register
	logic     valid_s1;
	byte_t    byte_s1;
	logic     end_s1;
	logic     repl_s1;

	// result register
	logic     out_valid_q;
	char_t    out_char_q;
	logic     out_end_q;
	logic     out_bad_q;

	dec_res_t res;
	char_t    mapped;
	logic     take_in;
	logic     advance;

	// a byte that yields nothing never waits for the result register
	assign advance  = valid_s1 && (!res.valid || !out_valid_q || out_ch.ready);
	assign take_in  = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= in_ch.in_byte;
			end_s1  <= in_ch.stream_end;
			repl_s1 <= in_ch.replace_delims;
		end
	end

	// sequence state and decode of the registered byte
	u8d_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.in_byte    (byte_s1),
		.stream_end (end_s1),
		.res        (res)
	);

	// range fold and delimiter replacement
	u8d_delim u_delim (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.code      (res.code),
		.replace   (repl_s1),
		.char_code (mapped)
	);

	// result register, refilled in the cycle it is drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			// end and error beats carry a zero character
			out_char_q <= res.emit ? mapped : CH_NUL;
			out_end_q  <= res.at_end;
			out_bad_q  <= res.bad;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.char_code    = out_char_q;
	assign out_ch.at_end       = out_end_q;
	assign out_ch.bad_sequence = out_bad_q;

endmodule

// File: src/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input u8d_pkg::char_t char_code,
	input logic           at_end,
	input logic           bad_sequence
);
	import u8d_pkg::*;

	// a held result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(char_code) && $stable(at_end)
			&& $stable(bad_sequence))
		else $error("result beat changed while stalled");

	// a result beat is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// an empty result register never stalls the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// end of stream beats carry no character
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_end |-> char_code == CH_NUL)
		else $error("end beat with nonzero character");

	// error beats carry no character
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_sequence |-> char_code == CH_NUL)
		else $error("error beat with nonzero character");

endmodule

bind utf8_decoder_with_delimiters u8d_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.char_code    (out_ch.char_code),
	.at_end       (out_ch.at_end),
	.bad_sequence (out_ch.bad_sequence)
);
